// ===== hw/rtl/mme_pkg.sv =====
`default_nettype none

package mme_pkg;

  // Field widths of one input beat and one result beat
  localparam int OP_W   = 2;
  localparam int POS_W  = 3;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int IN_W   = 24;  // 2 + 3 + 3 + 16, already whole bytes
  localparam int OUT_W  = 40;  // 3 + 3 + 32, padded up to 5 bytes

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY   = 2'd2;

  // Token that walks the cell chain, one per product element
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } token_t;

  // Element write broadcast to all cells
  typedef struct packed {
    logic             left_en;
    logic             right_en;
    logic [POS_W-1:0] cell_sel;
    logic [POS_W-1:0] addr;
    logic [VAL_W-1:0] value;
  } load_t;

  // Clamp a size register to 1..bound
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] value,
                                                input logic [CFG_W-1:0] bound);
    logic [CFG_W-1:0] v;
    v = value;
    if (v == '0) begin
      v = 4'd1;
    end
    if (v > bound) begin
      v = bound;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mme_cell.sv =====
`default_nettype none

// One shared-dimension position k: holds column k of A and row k of B,
// adds A[r][k]*B[k][c] to the partial sum passing through.
module mme_cell #(
  parameter int MAX_DIM  = 8,
  parameter int ACC_W    = 36,
  parameter int CELL_IDX = 0
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire [mme_pkg::CFG_W-1:0]       nk,
  input  wire mme_pkg::load_t            load,
  input  wire mme_pkg::token_t           tok_in,
  input  wire logic signed [ACC_W-1:0]   psum_in,
  output mme_pkg::token_t                tok_out,
  output logic signed [ACC_W-1:0]        psum_out
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam logic [mme_pkg::CFG_W-1:0] K = mme_pkg::CFG_W'(CELL_IDX);

  logic [mme_pkg::VAL_W-1:0] a_mem [MAX_DIM];
  logic [mme_pkg::VAL_W-1:0] b_mem [MAX_DIM];

  mme_pkg::token_t                  tok1;
  logic signed [ACC_W-1:0]          psum1;
  logic signed [mme_pkg::VAL_W-1:0] a1;
  logic signed [mme_pkg::VAL_W-1:0] b1;
  logic signed [mme_pkg::PROD_W-1:0] prod;
  logic                             sel_hit;
  logic                             mac_on;

  assign sel_hit = ({1'b0, load.cell_sel} == K);
  assign mac_on  = (K < nk);
  assign prod    = a1 * b1;

  // Element writes
  always_ff @(posedge clk) begin
    if (load.left_en && sel_hit) begin
      a_mem[IDX_W'(load.addr)] <= load.value;
    end
    if (load.right_en && sel_hit) begin
      b_mem[IDX_W'(load.addr)] <= load.value;
    end
  end

  // Stage 1: fetch operands; stage 2: accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1.valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok1.valid    <= tok_in.valid;
      tok_out.valid <= tok1.valid;
    end
    if (en) begin
      tok1.row  <= tok_in.row;
      tok1.col  <= tok_in.col;
      tok1.last <= tok_in.last;
      psum1     <= psum_in;
      a1        <= a_mem[IDX_W'(tok_in.row)];
      b1        <= b_mem[IDX_W'(tok_in.col)];
      tok_out.row  <= tok1.row;
      tok_out.col  <= tok1.col;
      tok_out.last <= tok1.last;
      psum_out     <= mac_on ? psum1 + ACC_W'(prod) : psum1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mme_seq.sv =====
`default_nettype none

// Walks the product elements in row-major order, one token per cycle while en is high.
module mme_seq (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       en,
  input  wire                       start,
  input  wire [mme_pkg::CFG_W-1:0]  nr,
  input  wire [mme_pkg::CFG_W-1:0]  nc,
  input  wire mme_pkg::token_t      tail,
  output mme_pkg::token_t           tok,
  output logic                      idle
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_t;

  state_t                     state;
  logic [mme_pkg::POS_W-1:0]  r;
  logic [mme_pkg::POS_W-1:0]  c;
  logic                       row_end;
  logic                       col_end;

  assign row_end = ({1'b0, r} == nr - 4'd1);
  assign col_end = ({1'b0, c} == nc - 4'd1);

  assign idle      = (state == S_IDLE);
  assign tok.valid = (state == S_ISSUE);
  assign tok.row   = r;
  assign tok.col   = c;
  assign tok.last  = row_end && col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      c     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ISSUE;
            r     <= '0;
            c     <= '0;
          end
        end
        S_ISSUE: begin
          if (en) begin
            if (col_end) begin
              c <= '0;
              if (row_end) begin
                state <= S_DRAIN;
              end else begin
                r <= r + 3'd1;
              end
            end else begin
              c <= c + 3'd1;
            end
          end
        end
        S_DRAIN: begin
          // hold until the marked token has left the chain
          if (en && tail.valid && tail.last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_multiply_engine_unit.sv =====
`default_nettype none

// Dense matrix multiply engine, C = A * B on signed Q8.8 elements.
// Input stream (s_axis): one beat per item. A load beat writes one element of
// A or B into the cell chain; a load outside the sizes set in the configuration
// registers is dropped. A multiply beat starts a run that emits every element
// of C in row-major order on m_axis, product_value in Q16.16 saturated to
// 32 bits, with m_axis_tlast on the final element.
// Structure: MAX_DIM identical cells in a row, cell k holding column k of A
// and row k of B. Each product element travels down the row as a token with
// its partial sum, two register stages per cell, so results stream out at
// one per cycle while m_axis is not stalled.
// s_axis_tready is low from the multiply beat until the last result has left
// the chain; the cell chain depth sets that drain time.
// A stall on m_axis freezes the whole chain and holds the output register.
// Reset (rst, synchronous) sets all sizes to 8 and empties the chain; the
// element stores hold garbage until loaded. Write configuration only while
// the engine is idle.
module matrix_multiply_engine_unit #(
  parameter int MAX_DIM = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  // config: register index 0 left_rows, 1 inner_size, 2 right_cols
  input  wire                              cfg_we,
  input  wire [mme_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire [mme_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: operation[1:0], row_index[4:2], col_index[7:5], element_value[23:8]
  input  wire [mme_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: out_row[2:0], out_col[5:3], product_value[37:6], zero pad[39:38]
  output logic [mme_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic                             m_axis_tlast
);

  localparam int ACC_W     = mme_pkg::PROD_W + $clog2(MAX_DIM) + 1;
  localparam int DIM_BOUND = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam logic [mme_pkg::CFG_W-1:0] BOUND = mme_pkg::CFG_W'(DIM_BOUND);

  // Configuration registers
  logic [mme_pkg::CFG_W-1:0] left_rows;
  logic [mme_pkg::CFG_W-1:0] inner_size;
  logic [mme_pkg::CFG_W-1:0] right_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows  <= 4'd8;
      inner_size <= 4'd8;
      right_cols <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_addr)
        mme_pkg::REG_LEFT_ROWS:  left_rows  <= cfg_wdata;
        mme_pkg::REG_INNER_SIZE: inner_size <= cfg_wdata;
        mme_pkg::REG_RIGHT_COLS: right_cols <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [mme_pkg::CFG_W-1:0] nr;
  logic [mme_pkg::CFG_W-1:0] nk;
  logic [mme_pkg::CFG_W-1:0] nc;

  assign nr = mme_pkg::eff_size(left_rows, BOUND);
  assign nk = mme_pkg::eff_size(inner_size, BOUND);
  assign nc = mme_pkg::eff_size(right_cols, BOUND);

  // Input beat decode
  logic [mme_pkg::OP_W-1:0]  in_op;
  logic [mme_pkg::POS_W-1:0] in_row;
  logic [mme_pkg::POS_W-1:0] in_col;
  logic [mme_pkg::VAL_W-1:0] in_val;
  logic                      in_acc;
  logic                      seq_idle;
  mme_pkg::load_t            load;

  assign in_op  = s_axis_tdata[1:0];
  assign in_row = s_axis_tdata[4:2];
  assign in_col = s_axis_tdata[7:5];
  assign in_val = s_axis_tdata[23:8];

  assign s_axis_tready = seq_idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // A[r][k] lives in cell k at address r; B[k][c] in cell k at address c
  always_comb begin
    load.left_en  = in_acc && (in_op == mme_pkg::OP_LOAD_LEFT) &&
                    ({1'b0, in_row} < nr) && ({1'b0, in_col} < nk);
    load.right_en = in_acc && (in_op == mme_pkg::OP_LOAD_RIGHT) &&
                    ({1'b0, in_row} < nk) && ({1'b0, in_col} < nc);
    load.cell_sel = (in_op == mme_pkg::OP_LOAD_LEFT) ? in_col : in_row;
    load.addr     = (in_op == mme_pkg::OP_LOAD_LEFT) ? in_row : in_col;
    load.value    = in_val;
  end

  // Chain advances whenever the output register can take a beat
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;

  mme_pkg::token_t         tok_chain  [MAX_DIM+1];
  logic signed [ACC_W-1:0] psum_chain [MAX_DIM+1];

  assign psum_chain[0] = '0;

  mme_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .start (in_acc && (in_op == mme_pkg::OP_MULTIPLY)),
    .nr    (nr),
    .nc    (nc),
    .tail  (tok_chain[MAX_DIM]),
    .tok   (tok_chain[0]),
    .idle  (seq_idle)
  );

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    mme_cell #(
      .MAX_DIM  (MAX_DIM),
      .ACC_W    (ACC_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .nk       (nk),
      .load     (load),
      .tok_in   (tok_chain[k]),
      .psum_in  (psum_chain[k]),
      .tok_out  (tok_chain[k+1]),
      .psum_out (psum_chain[k+1])
    );
  end

  // Saturate the full sum to 32 bits: fits when all bits above bit 30 agree
  logic signed [ACC_W-1:0]          tail_sum;
  logic [ACC_W-mme_pkg::PROD_W:0]   high_bits;
  logic [mme_pkg::PROD_W-1:0]       sat_val;

  assign tail_sum  = psum_chain[MAX_DIM];
  assign high_bits = tail_sum[ACC_W-1:mme_pkg::PROD_W-1];

  always_comb begin
    if ((high_bits == '0) || (high_bits == '1)) begin
      sat_val = tail_sum[mme_pkg::PROD_W-1:0];
    end else if (tail_sum[ACC_W-1]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  // Output register: advance with the chain, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= tok_chain[MAX_DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {2'b00, sat_val, tok_chain[MAX_DIM].col, tok_chain[MAX_DIM].row};
      m_axis_tlast <= tok_chain[MAX_DIM].last;
    end
  end

endmodule

`default_nettype wire
